// ===== rtl/lsm3_pkg.sv =====
// Shared types and constants for the 3x3 Laplacian sign mask unit.
`default_nettype none
package lsm3_pkg;

	localparam int CFG_W = 11;
	localparam int COORD_W = 10;
	localparam int QDEPTH = 4;
	localparam int QPW = 2;
	localparam int QCW = 3;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
	localparam logic [CFG_W-1:0] SIZE_MIN = 11'd3;

	// configuration register indexes
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [7:0] MASK_NEG = 8'hFF;
	localparam logic [7:0] MASK_POS = 8'h00;

	typedef logic [8:0][7:0] win_t;

	typedef struct packed {
		win_t win;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic last;
	} q_entry_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic empty;
	} q_stat_t;

	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
		int r;
		r = int'(v);
		if (v < SIZE_MIN) r = int'(SIZE_MIN);
		else if (r > hi) r = hi;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/laplacian_sign_mask_3x3_unit.sv =====
// Top level of the 3x3 Laplacian sign mask unit: config registers and wiring.
// Throughput: one pixel per cycle while in_stall is low; the output register and a
//   four-entry window queue let the input keep flowing while a result waits.
// Path: a completing pixel transfer loads the line memory reads into stage 1, then
//   the window update and queue write follow, then the Laplacian into output.
// Reset: counters, queue and output clear at once; then a clearing pass over all
//   MAX_WIDTH addresses zeroes both line memories, input stalled meanwhile.
`default_nettype none
module laplacian_sign_mask_3x3_unit import lsm3_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// pixel input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        pixel_in,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             mask_value,
	output logic [COORD_W-1:0]     out_column,
	output logic [COORD_W-1:0]     out_row,
	output logic                   frame_last,
	// configuration write port
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	// raw register contents; saturation to 3..MAX happens in the front end
	logic [CFG_W-1:0] cfg_width_q;
	logic [CFG_W-1:0] cfg_height_q;

	q_stat_t  q_stat;
	q_entry_t push_entry;
	q_entry_t head;
	logic     push;
	logic     pop;
	logic     clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q <= WIDTH_RESET;
			cfg_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  cfg_width_q <= cfg_data;
				REG_HEIGHT: cfg_height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// front: counters, line memories, window; pushes interior windows only
	lsm3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_in   (pixel_in),
		.cfg_width  (cfg_width_q),
		.cfg_height (cfg_height_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry),
		.clr_busy   (clr_busy)
	);

	// queue decouples the front from a stalled result channel
	lsm3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// back: Laplacian sign and output register
	lsm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mask_value (mask_value),
		.out_column (out_column),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

	// no pixel transfer while the line memories are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall)
		else $error("pixel accepted during line memory clear");

	// queue occupancy stays within its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCW'(QDEPTH))
		else $error("window queue count beyond depth");

	// the front's look-ahead stall must keep it from writing a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (q_stat.count < QCW'(QDEPTH)))
		else $error("window queue overflow");

endmodule
`default_nettype wire

// ===== rtl/lsm3_front.sv =====
// Front end: raster counters, line memories, 3x3 window, interior classification.
`default_nettype none
module lsm3_front import lsm3_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        pixel_in,
	input  wire logic [CFG_W-1:0]  cfg_width,
	input  wire logic [CFG_W-1:0]  cfg_height,
	input  wire q_stat_t           q_stat,
	output logic                   push,
	output q_entry_t               push_entry,
	output logic                   clr_busy
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [7:0] up_mem [MAX_WIDTH];
	logic [7:0] lo_mem [MAX_WIDTH];

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [AW-1:0] c_q, c_nx;
	logic [RW-1:0] r_q, r_nx;
	logic [WW-1:0] c_inc;
	logic [HW-1:0] r_inc;
	logic accept;
	logic is_int, is_last;
	logic [31:0] col_full, row_full;

	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic s1_valid;
	logic [7:0] px_s1, up_rd_s1, lo_rd_s1;
	logic [AW-1:0] idx_s1;
	logic int_s1, last_s1;
	logic [COORD_W-1:0] col_s1, row_s1;

	win_t win_q, win_nx;

	assign w_eff = WW'(clamp_size(cfg_width, MAX_WIDTH));
	assign h_eff = HW'(clamp_size(cfg_height, MAX_HEIGHT));

	assign in_stall = clr_busy_q ||
		((q_stat.count + QCW'(s1_valid)) >= QCW'(QDEPTH));
	assign accept = in_valid && !in_stall;
	assign clr_busy = clr_busy_q;

	assign c_inc = WW'(c_q) + WW'(1);
	assign r_inc = HW'(r_q) + HW'(1);

	// wrap as soon as a counter reaches or passes the current size
	always_comb begin
		if (c_inc >= w_eff) begin
			c_nx = '0;
			r_nx = (r_inc >= h_eff) ? '0 : RW'(r_inc);
		end else begin
			c_nx = AW'(c_inc);
			r_nx = (HW'(r_q) >= h_eff) ? '0 : r_q;
		end
	end

	assign is_int = (c_q >= AW'(2)) && (r_q >= RW'(2));
	assign is_last = (c_inc == w_eff) && (r_inc == h_eff);
	assign col_full = 32'(c_q) - 32'd1;
	assign row_full = 32'(r_q) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			s1_valid <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			s1_valid <= accept;
			if (accept) begin
				c_q <= c_nx;
				r_q <= r_nx;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= pixel_in;
			idx_s1 <= c_q;
			int_s1 <= is_int;
			last_s1 <= is_last;
			col_s1 <= col_full[COORD_W-1:0];
			row_s1 <= row_full[COORD_W-1:0];
		end
	end

	// line memories: read at the live column, write back in the following cycle
	always_ff @(posedge clk) begin
		up_rd_s1 <= up_mem[c_q];
		lo_rd_s1 <= lo_mem[c_q];
		if (clr_busy_q) begin
			up_mem[clr_addr_q] <= '0;
			lo_mem[clr_addr_q] <= '0;
		end else if (s1_valid) begin
			up_mem[idx_s1] <= lo_rd_s1;
			lo_mem[idx_s1] <= px_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nx[k*3 + 0] = win_q[k*3 + 1];
			win_nx[k*3 + 1] = win_q[k*3 + 2];
		end
		win_nx[2] = up_rd_s1;
		win_nx[5] = lo_rd_s1;
		win_nx[8] = px_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_valid) win_q <= win_nx;
	end

	assign push = s1_valid && int_s1;
	assign push_entry = '{win: win_nx, col: col_s1, row: row_s1, last: last_s1};

endmodule
`default_nettype wire

// ===== rtl/lsm3_queue.sv =====
// Short queue of complete windows between front and back.
`default_nettype none
module lsm3_queue import lsm3_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_entry,
	input  wire logic     pop,
	output q_entry_t      head,
	output q_stat_t       q_stat
);

	q_entry_t entries [QDEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPW'(1);
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries[wr_ptr_q] <= push_entry;
	end

	assign head = entries[rd_ptr_q];
	assign q_stat = '{count: count_q, empty: (count_q == '0)};

endmodule
`default_nettype wire

// ===== rtl/lsm3_back.sv =====
// Back end: Laplacian sign of a queued window into the output register.
`default_nettype none
module lsm3_back import lsm3_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire q_stat_t         q_stat,
	input  wire q_entry_t        head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           mask_value,
	output logic [COORD_W-1:0]   out_column,
	output logic [COORD_W-1:0]   out_row,
	output logic                 frame_last
);

	logic [10:0] nb_sum;
	logic [10:0] centre8;
	logic neg;

	// neighbours minus 8*centre < 0  <=>  neighbour sum < 8*centre
	always_comb begin
		nb_sum = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4) nb_sum = nb_sum + 11'(head.win[k]);
		end
	end

	assign centre8 = {head.win[4], 3'b000};
	assign neg = nb_sum < centre8;

	assign pop = !q_stat.empty && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_value <= neg ? MASK_NEG : MASK_POS;
			out_column <= head.col;
			out_row <= head.row;
			frame_last <= head.last;
		end
	end

endmodule
`default_nettype wire
